@@ sv/rsom_pkg.sv @@
// Shared types and constants for the radar speckle outlier mask block.
package rsom_pkg;

  // Default sample width, configuration word width and register index width
  localparam int SAMPLE_WIDTH_DEF = 32;
  localparam int CFG_DATA_W       = 32;
  localparam int CFG_IDX_W        = 3;

  // Sliding window and mark depths, results one gate can release, queue depth
  localparam int WIN_DEPTH        = 6;
  localparam int MARK_DEPTH       = 4;
  localparam int NUM_RES          = 4;
  localparam int QUEUE_DEPTH_DEF  = 4;

  // Register reset values
  localparam logic [CFG_DATA_W-1:0] MISSING_RST   = 32'd0;
  localparam logic [CFG_DATA_W-1:0] THRESHOLD_RST = 32'd0;
  localparam logic [CFG_DATA_W-1:0] MASK_RST      = 32'd65536;
  localparam logic [CFG_DATA_W-1:0] CLEAR_RST     = 32'd0;
  localparam logic                  UPWARD_RST    = 1'b1;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MISSING   = 3'd0,
    REG_THRESHOLD = 3'd1,
    REG_MASK      = 3'd2,
    REG_CLEAR     = 3'd3,
    REG_UPWARD    = 3'd4
  } reg_idx_t;

  // Register file contents
  typedef struct packed {
    logic [CFG_DATA_W-1:0] missing;
    logic [CFG_DATA_W-1:0] threshold;
    logic [CFG_DATA_W-1:0] mask;
    logic [CFG_DATA_W-1:0] clear;
    logic                  upward;
  } cfg_t;

  // Per-entry control: which result slots are live and which are masked.
  // Slot order is emission order; the last slot always closes the ray.
  typedef struct packed {
    logic [NUM_RES-1:0] vld;
    logic [NUM_RES-1:0] masked;
  } res_ctl_t;

  localparam int CTL_W = $bits(res_ctl_t);

endpackage

@@ sv/rsom_if.sv @@
// Channel interfaces: gate input, result output and register write port.
interface rsom_in_if #(parameter int SAMPLE_WIDTH = rsom_pkg::SAMPLE_WIDTH_DEF);
  logic                    valid;
  logic                    ready;
  logic [SAMPLE_WIDTH-1:0] sample;
  logic                    last_gate;

  modport source (output valid, output sample, output last_gate, input ready);
  modport sink   (input valid, input sample, input last_gate, output ready);
endinterface

interface rsom_out_if #(parameter int SAMPLE_WIDTH = rsom_pkg::SAMPLE_WIDTH_DEF);
  logic                    valid;
  logic                    ready;
  logic [SAMPLE_WIDTH-1:0] gate_value;
  logic                    masked;
  logic                    ray_end;

  modport source (output valid, output gate_value, output masked, output ray_end,
                  input ready);
  modport sink   (input valid, input gate_value, input masked, input ray_end,
                  output ready);
endinterface

interface rsom_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [rsom_pkg::CFG_IDX_W-1:0]   index;
  logic [rsom_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ sv/rsom_front.sv @@
// Front end: gate window, spike/dip classification and result bundling.
module rsom_front #(
  parameter int SAMPLE_WIDTH = rsom_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  rsom_pkg::cfg_t                              cfg,
  input  logic                                        accept,
  input  logic [SAMPLE_WIDTH-1:0]                     sample,
  input  logic                                        last_gate,
  output logic                                        push,
  output rsom_pkg::res_ctl_t                          push_ctl,
  output logic [rsom_pkg::NUM_RES*SAMPLE_WIDTH-1:0]   push_vals
);
  import rsom_pkg::*;

  localparam int SW = SAMPLE_WIDTH;

  // Register word read as an SW-bit two's complement value
  function automatic logic [SW-1:0] to_sw(input logic [CFG_DATA_W-1:0] v);
    logic [SW-1:0] r;
    for (int i = 0; i < SW; i++) begin
      r[i] = (i < CFG_DATA_W) ? v[i] : 1'b0;
    end
    return r;
  endfunction

  // a beyond both b and c by more than t, sums one bit wider
  function automatic logic beyond(input logic signed [SW-1:0] a,
                                  input logic signed [SW-1:0] b,
                                  input logic signed [SW-1:0] c,
                                  input logic signed [SW-1:0] t,
                                  input logic up);
    logic signed [SW:0] ae;
    logic signed [SW:0] lb;
    logic signed [SW:0] lc;
    ae = {a[SW-1], a};
    if (up) begin
      lb = {b[SW-1], b} + {t[SW-1], t};
      lc = {c[SW-1], c} + {t[SW-1], t};
      return (ae > lb) && (ae > lc);
    end else begin
      lb = {b[SW-1], b} - {t[SW-1], t};
      lc = {c[SW-1], c} - {t[SW-1], t};
      return (ae < lb) && (ae < lc);
    end
  endfunction

  // State
  logic signed [SW-1:0] win_val_r [WIN_DEPTH];
  logic [WIN_DEPTH-1:0] win_mis_r, win_mis_nxt;
  logic [MARK_DEPTH-1:0] marks_r, marks_nxt;
  logic                 skip_r, skip_nxt;
  logic [2:0]           seen_r, seen_nxt;

  // Shifted view of the window with the new gate at slot 0
  logic signed [SW-1:0] w [WIN_DEPTH];
  logic [WIN_DEPTH-1:0] m;
  logic [MARK_DEPTH-1:0] sh_mark;

  logic [SW-1:0] miss_sw, thr_sw, mask_sw, clear_sw;
  logic          test_en, hit3u, hit2u, hit3d, hit2d, do_down, pair;
  logic          mark3, mark2;
  logic [NUM_RES-1:0] slot_mis;
  logic [NUM_RES-1:0] slot_mark;

  assign miss_sw  = to_sw(cfg.missing);
  assign thr_sw   = to_sw(cfg.threshold);
  assign mask_sw  = to_sw(cfg.mask);
  assign clear_sw = to_sw(cfg.clear);

  always_comb begin
    w[0] = sample;
    m[0] = (sample == miss_sw);
    for (int k = 1; k < WIN_DEPTH; k++) begin
      w[k] = win_val_r[k-1];
      m[k] = win_mis_r[k-1];
    end
    sh_mark = {marks_r[MARK_DEPTH-2:0], 1'b0};
  end

  // Classification of the gate three back, and its follower for a pair
  always_comb begin
    test_en = (seen_r >= 3'd5) && !skip_r &&
              (mask_sw != miss_sw) && (clear_sw != miss_sw);
    hit3u   = !(m[3] | m[5] | m[1]) && beyond(w[3], w[5], w[1], thr_sw, 1'b1);
    hit2u   = hit3u && !(m[2] | m[4] | m[0]) &&
              beyond(w[2], w[4], w[0], thr_sw, 1'b1);
    hit3d   = !(m[3] | m[5] | m[1]) && beyond(w[3], w[5], w[1], thr_sw, 1'b0);
    hit2d   = hit3d && !(m[2] | m[4] | m[0]) &&
              beyond(w[2], w[4], w[0], thr_sw, 1'b0);
    do_down = !(sh_mark[3] | hit3u) && !cfg.upward;
    pair    = test_en && ((hit3u & hit2u) | (do_down & hit3d & hit2d));
    mark3   = sh_mark[3] | (test_en & (hit3u | (do_down & hit3d)));
    mark2   = sh_mark[2] | pair;

    if (seen_r >= 3'd5) begin
      skip_nxt = skip_r ? 1'b0 : pair;
    end else begin
      skip_nxt = skip_r;
    end
  end

  // Results released by this gate: slot 0, then on the last gate slots 1..3
  always_comb begin
    slot_mis  = {m[0], m[1], m[2], m[3]};
    slot_mark = {sh_mark[0], sh_mark[1], mark2, mark3};
    push_ctl.vld = {last_gate,
                    last_gate && (seen_r >= 3'd1),
                    last_gate && (seen_r >= 3'd2),
                    seen_r >= 3'd3};
    for (int i = 0; i < NUM_RES; i++) begin
      push_ctl.masked[i] = !slot_mis[i] && slot_mark[i];
      if (slot_mis[i]) begin
        push_vals[i*SW +: SW] = w[NUM_RES-1-i];
      end else if (slot_mark[i]) begin
        push_vals[i*SW +: SW] = mask_sw;
      end else begin
        push_vals[i*SW +: SW] = clear_sw;
      end
    end
    push = accept && (|push_ctl.vld);
  end

  // Next control state; the last gate returns the ray state to reset
  always_comb begin
    if (last_gate) begin
      win_mis_nxt = '0;
      marks_nxt   = '0;
      seen_nxt    = 3'd0;
    end else begin
      win_mis_nxt = m;
      marks_nxt   = {mark3, mark2, sh_mark[1:0]};
      seen_nxt    = (seen_r == 3'd7) ? seen_r : seen_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_mis_r <= '0;
      marks_r   <= '0;
      skip_r    <= 1'b0;
      seen_r    <= 3'd0;
    end else if (accept) begin
      win_mis_r <= win_mis_nxt;
      marks_r   <= marks_nxt;
      skip_r    <= last_gate ? 1'b0 : skip_nxt;
      seen_r    <= seen_nxt;
    end
  end

  // Window values need no reset: only slots of the current ray are read
  always_ff @(posedge clk) begin
    if (accept) begin
      for (int k = 0; k < WIN_DEPTH; k++) begin
        win_val_r[k] <= w[k];
      end
    end
  end

endmodule

@@ sv/rsom_fifo.sv @@
// Small register queue between the front and back ends.
module rsom_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full     = (cnt_r == FULL_CNT);
  assign empty    = (cnt_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PW'(1);
      end
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

@@ sv/rsom_back.sv @@
// Back end: walks the live slots of each queued bundle into the output register.
module rsom_back #(
  parameter int SAMPLE_WIDTH = rsom_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  logic                                       head_empty,
  input  rsom_pkg::res_ctl_t                         head_ctl,
  input  logic [rsom_pkg::NUM_RES*SAMPLE_WIDTH-1:0]  head_vals,
  output logic                                       pop,
  input  logic                                       out_ready,
  output logic                                       out_valid,
  output logic [SAMPLE_WIDTH-1:0]                    out_gate_value,
  output logic                                       out_masked,
  output logic                                       out_ray_end
);
  import rsom_pkg::*;

  localparam int SW = SAMPLE_WIDTH;

  logic [NUM_RES-1:0] done_r, done_nxt;
  logic [NUM_RES-1:0] remain, pick;
  logic               valid_r, valid_nxt, can_load, load;
  logic [SW-1:0]      val_r, val_nxt;
  logic               masked_r, masked_nxt, end_r, end_nxt;

  // Lowest live slot of the head bundle
  always_comb begin
    remain   = head_ctl.vld & ~done_r;
    pick     = remain & (~remain + NUM_RES'(1));
    can_load = !valid_r || out_ready;
    load     = !head_empty && can_load;
    pop      = load && ((remain & ~pick) == '0);

    val_nxt    = val_r;
    masked_nxt = masked_r;
    end_nxt    = end_r;
    for (int i = 0; i < NUM_RES; i++) begin
      if (pick[i]) begin
        val_nxt    = head_vals[i*SW +: SW];
        masked_nxt = head_ctl.masked[i];
        end_nxt    = (i == NUM_RES - 1);
      end
    end

    valid_nxt = valid_r;
    done_nxt  = done_r;
    if (load) begin
      valid_nxt = 1'b1;
      done_nxt  = pop ? '0 : (done_r | pick);
    end else if (can_load) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      done_r  <= '0;
    end else begin
      valid_r <= valid_nxt;
      done_r  <= done_nxt;
    end
  end

  // Output payload register
  always_ff @(posedge clk) begin
    if (load) begin
      val_r    <= val_nxt;
      masked_r <= masked_nxt;
      end_r    <= end_nxt;
    end
  end

  assign out_valid      = valid_r;
  assign out_gate_value = val_r;
  assign out_masked     = masked_r;
  assign out_ray_end    = end_r;

endmodule

@@ sv/radar_speckle_outlier_mask_core.sv @@
// Top level of the radar speckle outlier mask: registers, front, queue, back.
//
//   port    | dir | transfer                   | payload
//   --------+-----+----------------------------+--------------------------------
//   in_ch   | in  | one range gate             | sample, last_gate
//   out_ch  | out | one gate verdict           | gate_value, masked, ray_end
//   cfg_ch  | in  | one register write         | index, data
//
// The front takes one gate per cycle while the queue has room; a gate's verdict
// is bundled three gates later and passes through the queue and output register.
// The last gate of a ray releases up to four verdicts, which the back end drains
// one per cycle while out_ch is ready; the queue lets the front keep going.
// in_ch.ready drops only when the queue is full. cfg_ch.ready is always high.
// Synchronous active-low reset clears the ray state and loads register defaults.
module radar_speckle_outlier_mask_core #(
  parameter int SAMPLE_WIDTH = rsom_pkg::SAMPLE_WIDTH_DEF,
  parameter int QUEUE_DEPTH  = rsom_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  rsom_in_if.sink     in_ch,
  rsom_out_if.source  out_ch,
  rsom_cfg_if.sink    cfg_ch
);
  import rsom_pkg::*;

  localparam int VALS_W  = NUM_RES * SAMPLE_WIDTH;
  localparam int ENTRY_W = CTL_W + VALS_W;

  cfg_t               cfg_r;
  logic               in_accept, push, q_full, q_empty, pop;
  res_ctl_t           push_ctl, head_ctl;
  logic [VALS_W-1:0]  push_vals, head_vals;
  logic [ENTRY_W-1:0] push_data, head_data;

  // Register writes
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.missing   <= MISSING_RST;
      cfg_r.threshold <= THRESHOLD_RST;
      cfg_r.mask      <= MASK_RST;
      cfg_r.clear     <= CLEAR_RST;
      cfg_r.upward    <= UPWARD_RST;
    end else if (cfg_ch.valid) begin
      case (reg_idx_t'(cfg_ch.index))
        REG_MISSING:   cfg_r.missing   <= cfg_ch.data;
        REG_THRESHOLD: cfg_r.threshold <= cfg_ch.data;
        REG_MASK:      cfg_r.mask      <= cfg_ch.data;
        REG_CLEAR:     cfg_r.clear     <= cfg_ch.data;
        REG_UPWARD:    cfg_r.upward    <= cfg_ch.data[0];
        default: ;
      endcase
    end
  end

  // Front end
  assign in_ch.ready = !q_full;
  assign in_accept   = in_ch.valid && !q_full;

  rsom_front #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .accept    (in_accept),
    .sample    (in_ch.sample),
    .last_gate (in_ch.last_gate),
    .push      (push),
    .push_ctl  (push_ctl),
    .push_vals (push_vals)
  );

  // Queue of result bundles
  assign push_data = {push_ctl, push_vals};

  rsom_fifo #(.WIDTH(ENTRY_W), .DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .pop_data  (head_data),
    .empty     (q_empty)
  );

  assign head_ctl  = res_ctl_t'(head_data[ENTRY_W-1 -: CTL_W]);
  assign head_vals = head_data[VALS_W-1:0];

  // Back end
  rsom_back #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head_empty     (q_empty),
    .head_ctl       (head_ctl),
    .head_vals      (head_vals),
    .pop            (pop),
    .out_ready      (out_ch.ready),
    .out_valid      (out_ch.valid),
    .out_gate_value (out_ch.gate_value),
    .out_masked     (out_ch.masked),
    .out_ray_end    (out_ch.ray_end)
  );

endmodule
